// ===== rtl/stq_pkg.sv =====
`timescale 1ns / 1ps

package stq_pkg;

	localparam int ID_W     = 4;
	localparam int MAX_POPS = 16;
	localparam int POP_W    = $clog2(MAX_POPS + 1);

	typedef enum logic [1:0] {
		OP_SCHED_ABS = 2'd0,
		OP_SCHED_REL = 2'd1,
		OP_CANCEL    = 2'd2,
		OP_EXPIRE    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_PASS,
		ST_FLUSH,
		ST_EXP,
		ST_POPRD,
		ST_EMIT
	} state_t;

endpackage

// ===== rtl/stq_req_if.sv =====
`timescale 1ns / 1ps

interface stq_req_if #(
	parameter int TIME_BITS = 48
);
	logic                      valid;
	logic                      ready;
	logic [1:0]                opcode;
	logic [stq_pkg::ID_W-1:0]  timer_id;
	logic [TIME_BITS-1:0]      time_operand;
	logic [TIME_BITS-1:0]      now_ms;

	modport source (output valid, opcode, timer_id, time_operand, now_ms, input ready);
	modport sink   (input valid, opcode, timer_id, time_operand, now_ms, output ready);
endinterface

// ===== rtl/stq_rsp_if.sv =====
`timescale 1ns / 1ps

interface stq_rsp_if #(
	parameter int TIME_BITS = 48,
	parameter int CNT_W     = 5
);
	logic                      valid;
	logic                      ready;
	logic                      fired;
	logic [stq_pkg::ID_W-1:0]  fired_id;
	logic                      last_result;
	logic                      armed;
	logic [TIME_BITS-1:0]      next_due;
	logic [CNT_W-1:0]          queued_count;

	modport source (output valid, fired, fired_id, last_result, armed, next_due, queued_count,
		input ready);
	modport sink   (input valid, fired, fired_id, last_result, armed, next_due, queued_count,
		output ready);
endinterface

// ===== rtl/stq_ram.sv =====
`timescale 1ns / 1ps

module stq_ram #(
	parameter int WIDTH = 52,
	parameter int DEPTH = 16,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/stq_ctrl.sv =====
`timescale 1ns / 1ps

module stq_ctrl #(
	parameter int NUM_TIMERS = 16,
	parameter int TIME_BITS  = 48,
	localparam int AW        = $clog2(NUM_TIMERS),
	localparam int CW        = $clog2(NUM_TIMERS + 1),
	localparam int DW        = stq_pkg::ID_W + TIME_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               in_opcode,
	input  logic [stq_pkg::ID_W-1:0] in_id,
	input  logic [TIME_BITS-1:0]     in_operand,
	input  logic [TIME_BITS-1:0]     in_now,
	output logic                     res_valid,
	input  logic                     res_ready,
	output logic                     res_fired,
	output logic [stq_pkg::ID_W-1:0] res_id,
	output logic                     res_last,
	output logic                     res_armed,
	output logic [TIME_BITS-1:0]     res_next_due,
	output logic [CW-1:0]            res_count,
	output logic                     ram_we,
	output logic [AW-1:0]            ram_waddr,
	output logic [DW-1:0]            ram_wdata,
	output logic [AW-1:0]            ram_raddr,
	input  logic [DW-1:0]            ram_rdata
);
	import stq_pkg::*;

	localparam logic [CW:0] NUM = (CW + 1)'(NUM_TIMERS);

	state_t                 state_q, state_d;
	logic [CW-1:0]          cnt_q, rd_i_q, w_q;
	logic [AW-1:0]          base_q;
	logic                   pend_s1;
	logic                   ins_en_q, ins_done_q, found_q;
	logic                   carry_v_q;
	logic [DW-1:0]          carry_q;
	logic [ID_W-1:0]        id_q, head_tid_q, fire_id_q;
	logic [TIME_BITS-1:0]   due_q, now_q, head_due_q;
	logic [POP_W-1:0]       pops_q;
	logic                   fired_q, last_q;

	logic [ID_W-1:0]        e_tid;
	logic [TIME_BITS-1:0]   e_due;
	logic                   drop, do_ins, due_ok, scan_end;
	logic [TIME_BITS:0]     rel_sum;
	logic [TIME_BITS-1:0]   new_due;
	op_t                    op;

	function automatic logic [AW-1:0] phys(input logic [AW-1:0] b, input logic [CW-1:0] i);
		logic [CW:0] s;
		s = (CW + 1)'(b) + (CW + 1)'(i);
		if (s >= NUM) begin
			s = s - NUM;
		end
		return s[AW-1:0];
	endfunction

	assign e_tid    = ram_rdata[DW-1:TIME_BITS];
	assign e_due    = ram_rdata[TIME_BITS-1:0];
	assign drop     = pend_s1 && (e_tid == id_q);
	assign do_ins   = pend_s1 && ins_en_q && !ins_done_q && (due_q < e_due);
	assign scan_end = (rd_i_q == cnt_q) && !pend_s1;
	assign due_ok   = (pops_q < POP_W'(MAX_POPS)) && (cnt_q != '0) && (head_due_q <= now_q);
	assign op       = op_t'(in_opcode);
	// relative due time saturates at all ones
	assign rel_sum  = {1'b0, in_now} + {1'b0, in_operand};
	assign new_due  = (op == OP_SCHED_ABS) ? in_operand :
		(rel_sum[TIME_BITS] ? '1 : rel_sum[TIME_BITS-1:0]);

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		ram_we    = 1'b0;
		ram_wdata = {id_q, due_q};
		ram_waddr = phys(base_q, w_q);
		ram_raddr = phys(base_q, rd_i_q);
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (op)
						OP_EXPIRE: state_d = ST_EXP;
						OP_CANCEL: state_d = ST_PASS;
						default: state_d = (cnt_q == CW'(NUM_TIMERS)) ? ST_CHECK : ST_PASS;
					endcase
				end
			end
			ST_CHECK: begin
				if (scan_end) begin
					state_d = (found_q || drop) ? ST_PASS : ST_EMIT;
				end
			end
			ST_PASS: begin
				if (do_ins) begin
					ram_we = 1'b1;
				end else if (pend_s1 && !drop) begin
					ram_we    = 1'b1;
					ram_wdata = carry_v_q ? carry_q : ram_rdata;
				end
				if (scan_end) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (ins_en_q && !ins_done_q) begin
					ram_we = 1'b1;
				end else if (carry_v_q) begin
					ram_we    = 1'b1;
					ram_wdata = carry_q;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_EXP: begin
				ram_raddr = phys(base_q, CW'(1));
				if (due_ok && cnt_q > CW'(1)) begin
					state_d = ST_POPRD;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_POPRD: state_d = ST_EMIT;
			ST_EMIT: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = (fired_q && !last_q) ? ST_EXP : ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			base_q     <= '0;
			rd_i_q     <= '0;
			w_q        <= '0;
			pend_s1    <= 1'b0;
			ins_en_q   <= 1'b0;
			ins_done_q <= 1'b0;
			found_q    <= 1'b0;
			carry_v_q  <= 1'b0;
			pops_q     <= '0;
			fired_q    <= 1'b0;
			last_q     <= 1'b0;
		end else begin
			if (ram_we) begin
				w_q <= w_q + CW'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						rd_i_q     <= '0;
						w_q        <= '0;
						pend_s1    <= 1'b0;
						ins_en_q   <= (op == OP_SCHED_ABS) || (op == OP_SCHED_REL);
						ins_done_q <= 1'b0;
						found_q    <= 1'b0;
						carry_v_q  <= 1'b0;
						pops_q     <= '0;
						fired_q    <= 1'b0;
						last_q     <= 1'b1;
					end
				end
				ST_CHECK, ST_PASS: begin
					if (state_q == ST_CHECK && scan_end) begin
						rd_i_q  <= '0;
						pend_s1 <= 1'b0;
					end else if (rd_i_q < cnt_q) begin
						rd_i_q  <= rd_i_q + CW'(1);
						pend_s1 <= 1'b1;
					end else begin
						pend_s1 <= 1'b0;
					end
					if (state_q == ST_CHECK) begin
						found_q <= found_q || drop;
					end else if (do_ins) begin
						ins_done_q <= 1'b1;
						if (!drop) begin
							carry_v_q <= 1'b1;
						end
					end
				end
				ST_FLUSH: begin
					if (ins_en_q && !ins_done_q) begin
						ins_done_q <= 1'b1;
					end else if (carry_v_q) begin
						carry_v_q <= 1'b0;
					end else begin
						cnt_q <= w_q;
					end
				end
				ST_EXP: begin
					if (due_ok) begin
						fired_q <= 1'b1;
						cnt_q   <= cnt_q - CW'(1);
						base_q  <= phys(base_q, CW'(1));
						pops_q  <= pops_q + POP_W'(1);
						last_q  <= (cnt_q == CW'(1));
					end else begin
						fired_q <= 1'b0;
						last_q  <= 1'b1;
					end
				end
				ST_POPRD: begin
					last_q <= (pops_q == POP_W'(MAX_POPS)) || (e_due > now_q);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			id_q  <= in_id;
			due_q <= new_due;
			now_q <= in_now;
		end
		if (state_q == ST_PASS && pend_s1 && !drop) begin
			if (do_ins || carry_v_q) begin
				carry_q <= ram_rdata;
			end
		end
		// logical slot 0 is the head of the queue
		if (ram_we && w_q == '0) begin
			head_tid_q <= ram_wdata[DW-1:TIME_BITS];
			head_due_q <= ram_wdata[TIME_BITS-1:0];
		end
		if (state_q == ST_EXP && due_ok) begin
			fire_id_q <= head_tid_q;
		end
		if (state_q == ST_POPRD) begin
			head_tid_q <= e_tid;
			head_due_q <= e_due;
		end
	end

	assign res_fired    = fired_q;
	assign res_id       = fired_q ? fire_id_q : '0;
	assign res_last     = last_q;
	assign res_armed    = (cnt_q != '0);
	assign res_next_due = (cnt_q != '0) ? head_due_q : '0;
	assign res_count    = cnt_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(NUM_TIMERS))
		else $error("queue count beyond capacity");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PASS && ram_we) |-> (w_q < rd_i_q))
		else $error("compaction write overtook read");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q != ST_IDLE))
		else $error("accepted item not processed");

	a_fire_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_fired) |-> (pops_q != '0))
		else $error("fired result without a pop");
endmodule

// ===== rtl/sorted_timer_queue.sv =====
`timescale 1ns / 1ps

// Sorted timer queue. Up to NUM_TIMERS timers live in one RAM used as a ring of slots in
// due order; the head entry is mirrored in registers. Schedule and cancel rebuild the
// queue in one in-place streaming pass over the occupied slots before the result is
// offered; a schedule into a full queue adds a presence scan first. Expire pops one
// timer per result and reads the next head from the RAM before offering the result
// (no read for the pop that empties the queue). The input is taken again in the cycle
// after the last result leaves. Results pass through an output register, so a stalled
// consumer only holds the block.
module sorted_timer_queue #(
	parameter int NUM_TIMERS = 16,
	parameter int TIME_BITS  = 48
) (
	input  logic       clk,
	input  logic       arst_n,
	stq_req_if.sink    req,
	stq_rsp_if.source  rsp
);
	import stq_pkg::*;

	localparam int AW = $clog2(NUM_TIMERS);
	localparam int CW = $clog2(NUM_TIMERS + 1);
	localparam int DW = ID_W + TIME_BITS;

	logic                 ram_we;
	logic [AW-1:0]        ram_waddr, ram_raddr;
	logic [DW-1:0]        ram_wdata, ram_rdata;
	logic                 res_valid, res_ready;
	logic                 res_fired, res_last, res_armed;
	logic [ID_W-1:0]      res_id;
	logic [TIME_BITS-1:0] res_next_due;
	logic [CW-1:0]        res_count;

	logic                 rsp_v_q;
	logic                 fired_q, last_q, armed_q;
	logic [ID_W-1:0]      fired_id_q;
	logic [TIME_BITS-1:0] next_due_q;
	logic [CW-1:0]        count_q;

	stq_ram #(.WIDTH(DW), .DEPTH(NUM_TIMERS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	stq_ctrl #(.NUM_TIMERS(NUM_TIMERS), .TIME_BITS(TIME_BITS)) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (req.valid),
		.in_ready     (req.ready),
		.in_opcode    (req.opcode),
		.in_id        (req.timer_id),
		.in_operand   (req.time_operand),
		.in_now       (req.now_ms),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res_fired    (res_fired),
		.res_id       (res_id),
		.res_last     (res_last),
		.res_armed    (res_armed),
		.res_next_due (res_next_due),
		.res_count    (res_count),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata)
	);

	assign res_ready = !rsp_v_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_v_q <= 1'b0;
		end else if (res_ready) begin
			rsp_v_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			fired_q    <= res_fired;
			fired_id_q <= res_id;
			last_q     <= res_last;
			armed_q    <= res_armed;
			next_due_q <= res_next_due;
			count_q    <= res_count;
		end
	end

	assign rsp.valid        = rsp_v_q;
	assign rsp.fired        = fired_q;
	assign rsp.fired_id     = fired_id_q;
	assign rsp.last_result  = last_q;
	assign rsp.armed        = armed_q;
	assign rsp.next_due     = next_due_q;
	assign rsp.queued_count = count_q;
endmodule

// ===== verif/tb_stq_if_note.sv =====
`timescale 1ns / 1ps

// Channel interfaces come from the RTL (stq_req_if, stq_rsp_if); this file carries the
// record type of one expected response so the checker and predictor share it.
package tb_stq_types;

	typedef struct packed {
		logic        fired;
		logic [3:0]  fired_id;
		logic        last_result;
		logic        armed;
		logic [47:0] next_due;
		logic [4:0]  queued_count;
	} stq_resp_t;

endpackage

// ===== verif/tb_sorted_timer_queue.sv =====
`timescale 1ns / 1ps

module tb_sorted_timer_queue;
	import stq_pkg::*;
	import tb_stq_types::*;

	localparam int NT = 16;
	localparam logic [47:0] TMAX = 48'hFFFF_FFFF_FFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #1 clk = ~clk;

	stq_req_if #(.TIME_BITS(48)) req ();
	stq_rsp_if #(.TIME_BITS(48), .CNT_W(5)) rsp ();

	sorted_timer_queue #(.NUM_TIMERS(NT), .TIME_BITS(48)) DUT (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source)
	);

	// predictor state: sorted queue of (id, due)
	logic [3:0]  q_id [NT];
	logic [47:0] q_due [NT];
	int          q_cnt;
	stq_resp_t   pending_resp [$];

	int errors = 0;
	int n_sent = 0;
	int n_resp = 0;
	int n_fired = 0;
	bit hold_rsp = 1'b0;
	int hold_len = 0;
	bit no_stall = 1'b0;

	task automatic drop_at(input int pos);
		for (int i = pos; i + 1 < q_cnt; i++) begin
			q_id[i] = q_id[i + 1];
			q_due[i] = q_due[i + 1];
		end
		q_cnt--;
	endtask

	task automatic drop_id(input logic [3:0] id);
		for (int i = 0; i < q_cnt; i++)
			if (q_id[i] == id) begin
				drop_at(i);
				return;
			end
	endtask

	task automatic put_sorted(input logic [3:0] id, input logic [47:0] due);
		int pos;
		pos = 0;
		if (q_cnt >= NT) return;
		while (pos < q_cnt && !(due < q_due[pos])) pos++;
		for (int i = q_cnt; i > pos; i--) begin
			q_id[i] = q_id[i - 1];
			q_due[i] = q_due[i - 1];
		end
		q_id[pos] = id;
		q_due[pos] = due;
		q_cnt++;
	endtask

	function automatic stq_resp_t snap(input bit f, input logic [3:0] id, input bit last);
		stq_resp_t r;
		r.fired = f;
		r.fired_id = f ? id : 4'd0;
		r.last_result = last;
		r.armed = q_cnt > 0;
		r.next_due = q_cnt > 0 ? q_due[0] : 48'd0;
		r.queued_count = q_cnt[4:0];
		return r;
	endfunction

	task automatic predict_timer_op(input op_t op, input logic [3:0] id,
			input logic [47:0] operand, input logic [47:0] now);
		logic [48:0] sum;
		logic [47:0] due;
		logic [3:0]  fid;
		int k;
		k = 0;
		if (op == OP_SCHED_ABS || op == OP_SCHED_REL) begin
			due = operand;
			if (op == OP_SCHED_REL) begin
				sum = {1'b0, now} + {1'b0, operand};
				due = sum[48] ? TMAX : sum[47:0];
			end
			drop_id(id);
			put_sorted(id, due);
			pending_resp.push_back(snap(1'b0, 4'd0, 1'b1));
		end else if (op == OP_CANCEL) begin
			drop_id(id);
			pending_resp.push_back(snap(1'b0, 4'd0, 1'b1));
		end else begin
			while (k < MAX_POPS && q_cnt > 0 && q_due[0] <= now) begin
				fid = q_id[0];
				drop_at(0);
				pending_resp.push_back(snap(1'b1, fid,
					(k + 1 == MAX_POPS) || q_cnt == 0 || q_due[0] > now));
				k++;
			end
			if (k == 0) pending_resp.push_back(snap(1'b0, 4'd0, 1'b1));
		end
	endtask

	function automatic int short_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// valid stays up after a transfer when the next item follows at once
	task automatic send_timer_op(input op_t op, input logic [3:0] id,
			input logic [47:0] operand, input logic [47:0] now);
		int gap;
		gap = no_stall ? 0 : short_gap();
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.opcode <= op;
		req.timer_id <= id;
		req.time_operand <= operand;
		req.now_ms <= now;
		predict_timer_op(op, id, operand, now);
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		n_sent++;
	endtask

	task automatic wait_drained();
		req.valid <= 1'b0;
		while (pending_resp.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// response ready driver
	always @(posedge clk) begin
		if (hold_rsp) rsp.ready <= 1'b0;
		else if (no_stall) rsp.ready <= 1'b1;
		else if (hold_len > 0) begin
			rsp.ready <= 1'b0;
			hold_len <= hold_len - 1;
		end else begin
			rsp.ready <= 1'b1;
			if ($urandom_range(0, 99) < 20) hold_len <= short_gap();
		end
	end

	always @(posedge clk) begin
		stq_resp_t got, want;
		if (arst_n && rsp.valid && rsp.ready) begin
			got.fired = rsp.fired;
			got.fired_id = rsp.fired_id;
			got.last_result = rsp.last_result;
			got.armed = rsp.armed;
			got.next_due = rsp.next_due;
			got.queued_count = rsp.queued_count;
			n_resp++;
			if (got.fired) n_fired++;
			if (pending_resp.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected transfer: %p", got);
			end else begin
				want = pending_resp.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected %p, got %p", want, got);
				end
			end
		end
	end

	function automatic logic [47:0] rand48();
		return 48'({$urandom(), $urandom()} >> 16);
	endfunction

	task automatic test_directed_edges();
		send_timer_op(OP_EXPIRE, 4'd0, 48'd0, 48'd0);
		send_timer_op(OP_CANCEL, 4'd5, 48'd0, 48'd0);
		send_timer_op(OP_SCHED_ABS, 4'd15, TMAX, 48'd0);
		send_timer_op(OP_SCHED_ABS, 4'd0, 48'd0, TMAX);
		send_timer_op(OP_SCHED_REL, 4'd3, TMAX, TMAX);
		send_timer_op(OP_SCHED_REL, 4'd4, 48'd10, 48'd100);
		send_timer_op(OP_SCHED_ABS, 4'd6, 48'd110, 48'd0);
		send_timer_op(OP_SCHED_ABS, 4'd4, 48'd50, 48'd0);
		send_timer_op(OP_CANCEL, 4'd9, 48'd0, 48'd0);
		send_timer_op(OP_CANCEL, 4'd0, 48'd0, 48'd0);
		send_timer_op(OP_EXPIRE, 4'd0, 48'd0, 48'd49);
		send_timer_op(OP_EXPIRE, 4'd0, 48'd0, 48'd110);
		send_timer_op(OP_EXPIRE, 4'd0, 48'd0, TMAX);
	endtask

	// fill to capacity, reschedule and cancel while full, then a mass expire that reaches MAX_POPS
	task automatic test_full_queue();
		for (int i = 0; i < NT; i++)
			send_timer_op(OP_SCHED_ABS, i[3:0], 48'd5, 48'd0);
		send_timer_op(OP_SCHED_ABS, 4'd7, 48'd1, 48'd0);
		send_timer_op(OP_CANCEL, 4'd2, 48'd0, 48'd0);
		send_timer_op(OP_SCHED_ABS, 4'd2, 48'd5, 48'd0);
		send_timer_op(OP_SCHED_ABS, 4'd2, 48'd3, 48'd0);
		send_timer_op(OP_EXPIRE, 4'd0, 48'd0, 48'd5);
		send_timer_op(OP_EXPIRE, 4'd0, 48'd0, 48'd5);
	endtask

	task automatic test_random_ops(input int count);
		logic [47:0] now, opnd;
		op_t op;
		now = 48'd1000;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 9))
				0, 1, 2: op = OP_SCHED_ABS;
				3, 4: op = OP_SCHED_REL;
				5: op = OP_CANCEL;
				default: op = OP_EXPIRE;
			endcase
			now = now + 48'($urandom_range(0, 40));
			if ($urandom_range(0, 19) == 0) opnd = rand48();
			else if (op == OP_SCHED_ABS) opnd = now + 48'($urandom_range(0, 120));
			else opnd = 48'($urandom_range(0, 120));
			send_timer_op(op, 4'($urandom_range(0, 15)), opnd,
				$urandom_range(0, 29) == 0 ? rand48() : now);
		end
		send_timer_op(OP_EXPIRE, 4'd0, 48'd0, TMAX);
	endtask

	// receiver stops for a long stretch while requests keep coming
	task automatic test_backpressure();
		hold_rsp = 1'b1;
		fork
			for (int i = 0; i < 24; i++)
				send_timer_op(OP_SCHED_ABS, 4'($urandom_range(0, 15)),
					48'($urandom_range(0, 500)), 48'd0);
			begin
				repeat (300) @(posedge clk);
				hold_rsp = 1'b0;
			end
		join
		no_stall = 1'b1;
		send_timer_op(OP_EXPIRE, 4'd0, 48'd0, TMAX);
		wait_drained();
		no_stall = 1'b0;
	endtask

	initial begin
		req.valid = 1'b0;
		req.opcode = OP_SCHED_ABS;
		req.timer_id = '0;
		req.time_operand = '0;
		req.now_ms = '0;
		rsp.ready = 1'b0;
		q_cnt = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_edges();
		test_full_queue();
		wait_drained();
		test_random_ops(200);
		test_backpressure();
		test_random_ops(200);
		wait_drained();
		repeat (50) @(posedge clk);
		$display("Sent %0d requests, checked %0d responses (%0d expirations).",
			n_sent, n_resp, n_fired);
		if (errors == 0) $display("PASSED: all results match");
		else $display("FAILED: results differ");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/stq_pkg.sv
rtl/stq_req_if.sv
rtl/stq_rsp_if.sv
rtl/stq_ram.sv
rtl/stq_ctrl.sv
rtl/sorted_timer_queue.sv
verif/tb_stq_if_note.sv
verif/tb_sorted_timer_queue.sv
